>>> src/kcg_pkg.sv
// ----------------------------------------------------------------------------
// kcg_pkg
// Shared types and constants for the key click and gesture detector.
// ----------------------------------------------------------------------------
package kcg_pkg;

  localparam int KEY_COUNT = 8;
  localparam int KEY_W     = 3;
  localparam int HIST_W    = 5;
  localparam int PHASE_W   = 3;
  localparam int TICK_W    = 16;
  localparam int CLICK_W   = 10;
  localparam int GEST_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_GAP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD  = 2'd3;

  // Configuration reset values.
  localparam logic [KEY_COUNT-1:0] LEVEL_MASK_RST = '0;
  localparam logic [CLICK_W-1:0]   CLICK_MAX_RST  = 10'd60;
  localparam logic [CLICK_W-1:0]   DOUBLE_GAP_RST = 10'd40;
  localparam logic [TICK_W-1:0]    LONG_HOLD_RST  = 16'd400;

  // Gesture phases.
  localparam logic [PHASE_W-1:0] PH_IDLE         = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PRESSED      = 3'd1;
  localparam logic [PHASE_W-1:0] PH_GAP          = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LONG         = 3'd3;
  localparam logic [PHASE_W-1:0] PH_AFTER_DOUBLE = 3'd4;

  // Gesture codes.
  localparam logic [GEST_W-1:0] G_NONE         = 3'd0;
  localparam logic [GEST_W-1:0] G_CLICK        = 3'd1;
  localparam logic [GEST_W-1:0] G_DOUBLE       = 3'd2;
  localparam logic [GEST_W-1:0] G_LONG_START   = 3'd3;
  localparam logic [GEST_W-1:0] G_LONG_HOLD    = 3'd4;
  localparam logic [GEST_W-1:0] G_LONG_RELEASE = 3'd5;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  // Per-key state word held in the state memory.
  typedef struct packed {
    logic [HIST_W-1:0]  history;
    logic               stable;
    logic [PHASE_W-1:0] phase;
    logic [TICK_W-1:0]  ticks;
    logic               hold_done;
  } key_state_t;

  typedef struct packed {
    logic [KEY_COUNT-1:0] level_mask;
    logic [CLICK_W-1:0]   click_max;
    logic [CLICK_W-1:0]   double_gap;
    logic [TICK_W-1:0]    long_hold;
  } cfg_t;

  typedef struct packed {
    logic              press_edge;
    logic              release_edge;
    logic [GEST_W-1:0] gesture;
    logic [TICK_W-1:0] long_ticks;
  } key_event_t;

endpackage

>>> src/kcg_state_mem.sv
// ----------------------------------------------------------------------------
// kcg_state_mem
// Per-key state memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module kcg_state_mem import kcg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [KEY_W-1:0] rd_key,
  output key_state_t       rd_state,
  input  logic             wr_en,
  input  logic [KEY_W-1:0] wr_key,
  input  key_state_t       wr_state
);

  key_state_t           mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] written;

  // An entry that was never written since reset reads as all zero.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_key] <= wr_state;
    end
    if (rd_en) begin
      rd_state <= written[rd_key] ? mem[rd_key] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_key] <= 1'b1;
    end
  end

endmodule

>>> src/kcg_update.sv
// ----------------------------------------------------------------------------
// kcg_update
// Debounce and gesture classification for one key sample.
// ----------------------------------------------------------------------------
module kcg_update import kcg_pkg::*; (
  input  cfg_t             cfg,
  input  logic [KEY_W-1:0] key,
  input  logic             pin,
  input  key_state_t       cur,
  output key_state_t       nxt,
  output key_event_t       evt
);

  logic              key_ok;
  logic              pressed;
  logic              st;
  logic [TICK_W-1:0] t_inc;
  logic [TICK_W-1:0] t;
  key_state_t        upd;
  key_event_t        res;

  assign key_ok = ({1'b0, key} < (KEY_W+1)'(KEY_COUNT));
  assign t_inc  = (cur.ticks == TICK_MAX) ? cur.ticks : cur.ticks + TICK_W'(1);

  always_comb begin
    upd     = cur;
    res     = '0;
    pressed = (pin == cfg.level_mask[key]);
    st      = cur.stable;
    t       = cur.ticks;

    // The stable state follows once the current sample and the four previous samples agree.
    if (pressed) begin
      if (cur.history[3:0] == 4'hF) begin
        st             = 1'b1;
        res.press_edge = ~cur.history[4];
      end
      upd.history = {cur.history[3:0], 1'b1};
    end else begin
      if (cur.history[3:0] == 4'h0) begin
        st               = 1'b0;
        res.release_edge = cur.history[4];
      end
      upd.history = {cur.history[3:0], 1'b0};
    end
    upd.stable = st;

    case (cur.phase)
      PH_PRESSED: begin
        t = t_inc;
        if (t > TICK_W'(cfg.click_max)) begin
          res.gesture = G_LONG_START;
          upd.phase   = PH_LONG;
        end else if (!st) begin
          upd.phase = PH_GAP;
          t         = '0;
        end
      end
      PH_LONG: begin
        t = t_inc;
        if (!st) begin
          res.gesture    = G_LONG_RELEASE;
          res.long_ticks = t;
          upd.phase      = PH_IDLE;
          t              = '0;
          upd.hold_done  = 1'b0;
        end
        if (t > cfg.long_hold && !upd.hold_done) begin
          upd.hold_done = 1'b1;
          res.gesture   = G_LONG_HOLD;
        end
      end
      PH_GAP: begin
        t = t_inc;
        if (t > TICK_W'(cfg.double_gap)) begin
          res.gesture = G_CLICK;
          upd.phase   = PH_IDLE;
          t           = '0;
        end else if (st) begin
          res.gesture = G_DOUBLE;
          upd.phase   = PH_AFTER_DOUBLE;
        end
      end
      PH_AFTER_DOUBLE: begin
        if (!st) begin
          upd.phase = PH_IDLE;
          t         = '0;
        end
      end
      default: begin
        t         = '0;
        upd.phase = st ? PH_PRESSED : PH_IDLE;
      end
    endcase
    upd.ticks = t;

    if (key_ok) begin
      nxt = upd;
      evt = res;
    end else begin
      nxt = cur;
      evt = '0;
    end
  end

endmodule

>>> src/key_click_gesture_detector_unit.sv
// ----------------------------------------------------------------------------
// key_click_gesture_detector_unit
// Debounces per-key scan samples and reports edges and click gestures.
//
//   Channel  Handshake            Payload
//   in       in_valid/in_ready    key_index, pin_level
//   out      out_valid/out_ready  event_key, press_edge, release_edge,
//                                 gesture, long_ticks
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One sample per cycle unless the output stalls; each result passes stage s1
// and the output register. The state memory is read at acceptance and written
// back as the sample leaves s1; a bypass register covers same-key back-to-back samples.
// Reset loads the configuration reset values and marks every key state as all zero.
// A stalled output holds the pipeline; cfg_ready is always high.
// ----------------------------------------------------------------------------
module key_click_gesture_detector_unit import kcg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KEY_W-1:0]     key_index,
  input  logic                 pin_level,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KEY_W-1:0]     event_key,
  output logic                 press_edge,
  output logic                 release_edge,
  output logic [GEST_W-1:0]    gesture,
  output logic [TICK_W-1:0]    long_ticks,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t             cfg;
  logic             s1_valid;
  logic [KEY_W-1:0] s1_key;
  logic             s1_pin;
  logic             s1_adv;
  logic             in_acc;
  logic             byp_sel;
  key_state_t       byp_state;
  key_state_t       rd_state;
  key_state_t       cur_state;
  key_state_t       new_state;
  key_event_t       evt;
  logic             wr_en;

  assign cfg_ready = 1'b1;
  assign s1_adv    = ~out_valid | out_ready;
  assign in_ready  = ~s1_valid | s1_adv;
  assign in_acc    = in_valid & in_ready;
  assign wr_en     = s1_valid & s1_adv;
  assign cur_state = byp_sel ? byp_state : rd_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_mask <= LEVEL_MASK_RST;
      cfg.click_max  <= CLICK_MAX_RST;
      cfg.double_gap <= DOUBLE_GAP_RST;
      cfg.long_hold  <= LONG_HOLD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LEVEL_MASK: cfg.level_mask <= cfg_data[KEY_COUNT-1:0];
        CFG_CLICK_MAX:  cfg.click_max  <= cfg_data[CLICK_W-1:0];
        CFG_DOUBLE_GAP: cfg.double_gap <= cfg_data[CLICK_W-1:0];
        CFG_LONG_HOLD:  cfg.long_hold  <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  kcg_state_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_acc),
    .rd_key   (key_index),
    .rd_state (rd_state),
    .wr_en    (wr_en),
    .wr_key   (s1_key),
    .wr_state (new_state)
  );

  kcg_update u_update (
    .cfg (cfg),
    .key (s1_key),
    .pin (s1_pin),
    .cur (cur_state),
    .nxt (new_state),
    .evt (evt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      byp_sel  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
        // The memory read misses a write to the same key at this edge.
        byp_sel  <= wr_en & (s1_key == key_index);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
        byp_sel  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_key    <= key_index;
      s1_pin    <= pin_level;
      byp_state <= new_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      event_key    <= s1_key;
      press_edge   <= evt.press_edge;
      release_edge <= evt.release_edge;
      gesture      <= evt.gesture;
      long_ticks   <= evt.long_ticks;
    end
  end

  a_edges_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(press_edge && release_edge))
    else $error("press and release edge reported together");

  a_long_ticks_only_on_release: assert property (@(posedge clk) disable iff (rst)
    (out_valid && long_ticks != '0) |-> (gesture == G_LONG_RELEASE))
    else $error("long_ticks set without a long release");

  a_release_has_duration: assert property (@(posedge clk) disable iff (rst)
    (out_valid && gesture == G_LONG_RELEASE) |-> (long_ticks != '0))
    else $error("long release reported with zero duration");

  a_bypass_has_item: assert property (@(posedge clk) disable iff (rst)
    byp_sel |-> s1_valid)
    else $error("bypass selected without an item in flight");

endmodule
